>>> design/durw_pkg.sv
// ----------------------------------------------------------------------------
// durw_pkg
// Event codes, sensor codes, register indexes and fixed constants of the
// dual ultrasonic ranger with proximity warning.
// ----------------------------------------------------------------------------
`default_nettype none

package durw_pkg;

    localparam int DEF_TIMER_WIDTH = 16;

    localparam int FUNC_W    = 2;
    localparam int CAP_W     = 16;
    localparam int SENSOR_W  = 2;
    localparam int DIST_W    = 10;
    localparam int SLOT_W    = 4;
    localparam int WARN_W    = 9;
    localparam int BLINK_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [SENSOR_W-1:0] sensor_t;
    typedef logic [DIST_W-1:0]   dist_t;

    localparam func_t FUNC_TICK     = 2'd0;
    localparam func_t FUNC_ECHO_ONE = 2'd1;
    localparam func_t FUNC_ECHO_TWO = 2'd2;

    localparam sensor_t SENSOR_NONE = 2'd0;
    localparam sensor_t SENSOR_ONE  = 2'd1;
    localparam sensor_t SENSOR_TWO  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_CM         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CM          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLINK_SLOTS = 2'd3;

    localparam logic [SLOT_W-1:0]  RST_SLOT_TICKS      = 4'd5;
    localparam logic [WARN_W-1:0]  RST_WARN_CM         = 9'd40;
    localparam logic [DIST_W-1:0]  RST_MAX_CM          = 10'd380;
    localparam logic [BLINK_W-1:0] RST_MAX_BLINK_SLOTS = 4'd4;

    // echo width per cm is 2*58 timer counts
    localparam logic [16:0] COUNTS_PER_CM = 17'd116;
    // floor(x/29) = (x * RECIP_29) >> RECIP_29_SHIFT, exact for x < 2^15
    localparam logic [30:0] RECIP_29       = 31'd36158;
    localparam int          RECIP_29_SHIFT = 20;
    // floor(d/10) = (d * RECIP_10) >> RECIP_10_SHIFT, exact for d < 1024
    localparam logic [17:0] RECIP_10       = 18'd205;
    localparam int          RECIP_10_SHIFT = 11;

endpackage

`default_nettype wire

>>> design/dual_ultrasonic_ranger_warning.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger_warning
// Two-sensor ultrasonic ranging controller with blinking proximity warning.
//
// Input channel (in_valid/in_stall) carries one event per item: a tick, or an
// echo edge of sensor one or two with its timer capture. Output channel
// (out_valid/out_stall) returns exactly one result item per event: the sensor
// triggered by it, both stored distances, buzzer/lamp drive and warning flag.
// An item is taken when valid is high and stall is low.
// Two registers: input register, then all state update and result in
// one pass into the output register. Throughput is one item per cycle; the
// input register keeps accepting while a result waits under out_stall, and
// in_stall rises only when both registers are full and the output is stalled.
// Pulse width to cm uses one 15x31 constant multiply; the blink period uses
// two small constant multiplies, all within that one pass.
// Reset (rst_n low, async) clears both channels, loads register defaults,
// arms sensor one and clears distances, edge flags, blink and warning state.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and
// are meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_ultrasonic_ranger_warning #(
    parameter int TIMER_WIDTH = durw_pkg::DEF_TIMER_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_we,
    input  wire logic [durw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [durw_pkg::CFG_W-1:0]         cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [durw_pkg::FUNC_W-1:0]        func,
    input  wire logic [durw_pkg::CAP_W-1:0]         capture_time,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [durw_pkg::SENSOR_W-1:0]           trigger_sensor,
    output logic [durw_pkg::DIST_W-1:0]             distance_one,
    output logic [durw_pkg::DIST_W-1:0]             distance_two,
    output logic                                    buzzer_on,
    output logic                                    lamp_on,
    output logic                                    warning_active
);

    import durw_pkg::*;

    localparam int CW = (TIMER_WIDTH > 17) ? TIMER_WIDTH : 17;

    // configuration
    logic [SLOT_W-1:0]  slot_ticks_reg;
    logic [WARN_W-1:0]  warn_cm_reg;
    logic [DIST_W-1:0]  max_cm_reg;
    logic [BLINK_W-1:0] max_blink_reg;

    // input register
    logic              s1_valid_reg;
    func_t             s1_func_reg;
    logic [CAP_W-1:0]  s1_cap_reg;

    // output register
    logic              out_valid_reg;
    sensor_t           out_trig_reg;
    dist_t             out_d1_reg;
    dist_t             out_d2_reg;
    logic              out_level_reg;
    logic              out_warn_reg;

    // ranging state
    logic [SLOT_W-1:0]      tick_reg, tick_next;
    logic                   slot_two_reg, slot_two_next;
    sensor_t                armed_reg, armed_next;
    logic [1:0]             seen_reg, seen_next;
    logic [TIMER_WIDTH-1:0] start_reg [2];
    logic [TIMER_WIDTH-1:0] start_next [2];
    dist_t                  dist_reg [2];
    dist_t                  dist_next [2];
    logic [BLINK_W-1:0]     blink_reg, blink_next;
    logic                   level_reg, level_next;
    logic                   warn_reg, warn_next;
    sensor_t                trig;

    logic adv;
    logic in_fire;

    assign adv      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign in_fire  = in_valid && !in_stall;

    // echo pulse width to cm
    logic                   sel;
    logic [TIMER_WIDTH-1:0] cap_t;
    logic [TIMER_WIDTH-1:0] pulse_w;
    logic [16:0]            limit;
    logic                   in_range;
    logic [16:0]            w17;
    logic [30:0]            prod;
    dist_t                  cm;

    assign sel      = (s1_func_reg == FUNC_ECHO_TWO);
    assign cap_t    = TIMER_WIDTH'(s1_cap_reg);
    assign pulse_w  = cap_t - start_reg[sel];
    assign limit    = ({7'b0, max_cm_reg} + 17'd1) * COUNTS_PER_CM;
    assign in_range = CW'(pulse_w) < CW'(limit);
    assign w17      = 17'(pulse_w);
    assign prod     = {16'b0, w17[16:2]} * RECIP_29;
    assign cm       = prod[RECIP_29_SHIFT+DIST_W-1:RECIP_29_SHIFT];

    // blink period
    logic [17:0] q1_prod, q2_prod;
    logic [6:0]  p1, p2, pmin;
    logic [3:0]  lim;
    logic [3:0]  period;
    logic        warn_now;

    assign q1_prod  = {8'b0, dist_reg[0]} * RECIP_10;
    assign q2_prod  = {8'b0, dist_reg[1]} * RECIP_10;
    assign p1       = q1_prod[RECIP_10_SHIFT+6:RECIP_10_SHIFT] + 7'd1;
    assign p2       = q2_prod[RECIP_10_SHIFT+6:RECIP_10_SHIFT] + 7'd1;
    assign pmin     = (p1 < p2) ? p1 : p2;
    assign lim      = (max_blink_reg == 4'd0) ? 4'd1 : max_blink_reg;
    assign period   = (pmin > {3'b0, lim}) ? lim : pmin[3:0];
    assign warn_now = ({1'b0, warn_cm_reg} >= dist_reg[0])
                   || ({1'b0, warn_cm_reg} >= dist_reg[1]);

    always_comb
    begin
        tick_next     = tick_reg;
        slot_two_next = slot_two_reg;
        armed_next    = armed_reg;
        seen_next     = seen_reg;
        start_next    = start_reg;
        dist_next     = dist_reg;
        blink_next    = blink_reg;
        level_next    = level_reg;
        warn_next     = warn_reg;
        trig          = SENSOR_NONE;
        unique case (s1_func_reg)
            FUNC_TICK:
            begin
                if ({1'b0, tick_reg} + 5'd1 >= {1'b0, slot_ticks_reg})
                begin
                    tick_next     = '0;
                    slot_two_next = !slot_two_reg;
                    armed_next    = slot_two_reg ? SENSOR_ONE : SENSOR_TWO;
                    trig          = slot_two_reg ? SENSOR_ONE : SENSOR_TWO;
                    warn_next     = warn_now;
                    if (warn_now)
                    begin
                        if ({1'b0, blink_reg} + 5'd1 >= {1'b0, period})
                        begin
                            blink_next = '0;
                            level_next = !level_reg;
                        end
                        else
                        begin
                            blink_next = blink_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        level_next = 1'b0;
                    end
                end
                else
                begin
                    tick_next = tick_reg + 4'd1;
                end
            end
            FUNC_ECHO_ONE, FUNC_ECHO_TWO:
            begin
                if (armed_reg == (sel ? SENSOR_TWO : SENSOR_ONE))
                begin
                    if (!seen_reg[sel])
                    begin
                        start_next[sel] = cap_t;
                        seen_next[sel]  = 1'b1;
                    end
                    else
                    begin
                        if (in_range)
                        begin
                            dist_next[sel] = cm;
                        end
                        seen_next[sel] = 1'b0;
                        armed_next     = SENSOR_NONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ticks_reg <= RST_SLOT_TICKS;
            warn_cm_reg    <= RST_WARN_CM;
            max_cm_reg     <= RST_MAX_CM;
            max_blink_reg  <= RST_MAX_BLINK_SLOTS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLOT_TICKS:      slot_ticks_reg <= cfg_data[SLOT_W-1:0];
                CFG_WARN_CM:         warn_cm_reg    <= cfg_data[WARN_W-1:0];
                CFG_MAX_CM:          max_cm_reg     <= cfg_data[DIST_W-1:0];
                CFG_MAX_BLINK_SLOTS: max_blink_reg  <= cfg_data[BLINK_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg <= func;
            s1_cap_reg  <= capture_time;
        end
        if (adv)
        begin
            out_trig_reg  <= trig;
            out_d1_reg    <= dist_next[0];
            out_d2_reg    <= dist_next[1];
            out_level_reg <= level_next;
            out_warn_reg  <= warn_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            slot_two_reg <= 1'b0;
            armed_reg    <= SENSOR_ONE;
            seen_reg     <= '0;
            start_reg[0] <= '0;
            start_reg[1] <= '0;
            dist_reg[0]  <= '0;
            dist_reg[1]  <= '0;
            blink_reg    <= '0;
            level_reg    <= 1'b0;
            warn_reg     <= 1'b0;
        end
        else if (adv)
        begin
            tick_reg     <= tick_next;
            slot_two_reg <= slot_two_next;
            armed_reg    <= armed_next;
            seen_reg     <= seen_next;
            start_reg    <= start_next;
            dist_reg     <= dist_next;
            blink_reg    <= blink_next;
            level_reg    <= level_next;
            warn_reg     <= warn_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_sensor = out_trig_reg;
    assign distance_one   = out_d1_reg;
    assign distance_two   = out_d2_reg;
    assign buzzer_on      = out_level_reg;
    assign lamp_on        = out_level_reg;
    assign warning_active = out_warn_reg;

endmodule

`default_nettype wire

>>> tb/ranger_tb_pkg.sv
// ----------------------------------------------------------------------------
// ranger_tb_pkg
// Result item type, spare event code and the scoreboard for the dual
// ultrasonic ranger. The scoreboard predicts each result from the events as
// they are accepted and checks the block's results in order against it.
// ----------------------------------------------------------------------------
package ranger_tb_pkg;

    import durw_pkg::*;

    localparam func_t FUNC_UNUSED = 2'd3;

    typedef struct packed {
        sensor_t trig;
        dist_t   dist_one;
        dist_t   dist_two;
        logic    buzzer;
        logic    lamp;
        logic    warn;
    } ranger_report_t;

    class ranger_scoreboard;
        logic [SLOT_W-1:0]  slot_len;
        logic [WARN_W-1:0]  warn_lim;
        dist_t              range_lim;
        logic [BLINK_W-1:0] blink_lim;

        logic [3:0]         tick_cnt;
        sensor_t            cur_slot;
        sensor_t            armed;
        logic               edge_pending [2];
        logic [CAP_W-1:0]   edge_base [2];
        dist_t              dist_cm [2];
        logic [3:0]         blink_cnt;
        logic               buzzer;
        logic               lamp;
        logic               warn;

        ranger_report_t     expected_reports [$];
        int                 mismatches;
        int                 checked;
        int                 triggers;
        int                 warned;
        int                 stored_reads;

        function new();
            slot_len  = RST_SLOT_TICKS;
            warn_lim  = RST_WARN_CM;
            range_lim = RST_MAX_CM;
            blink_lim = RST_MAX_BLINK_SLOTS;
            tick_cnt  = '0;
            cur_slot  = SENSOR_ONE;
            armed     = SENSOR_ONE;
            for (int i = 0; i < 2; i++)
            begin
                edge_pending[i] = 1'b0;
                edge_base[i]    = '0;
                dist_cm[i]      = '0;
            end
            blink_cnt = '0;
            buzzer    = 1'b0;
            lamp      = 1'b0;
            warn      = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_SLOT_TICKS:      slot_len  = val[SLOT_W-1:0];
                CFG_WARN_CM:         warn_lim  = val[WARN_W-1:0];
                CFG_MAX_CM:          range_lim = val[DIST_W-1:0];
                CFG_MAX_BLINK_SLOTS: blink_lim = val[BLINK_W-1:0];
                default:             ;
            endcase
        endfunction

        function void end_slot();
            int p1;
            int p2;
            int period;
            int lim;
            int nxt;
            cur_slot = (cur_slot == SENSOR_ONE) ? SENSOR_TWO : SENSOR_ONE;
            armed    = cur_slot;
            warn     = (dist_cm[0] <= warn_lim) || (dist_cm[1] <= warn_lim);
            p1       = dist_cm[0] / 10 + 1;
            p2       = dist_cm[1] / 10 + 1;
            period   = (p1 < p2) ? p1 : p2;
            lim      = (blink_lim == 0) ? 1 : blink_lim;
            if (period > lim)
                period = lim;
            if (warn)
            begin
                nxt = blink_cnt + 1;
                if (nxt >= period)
                begin
                    blink_cnt = '0;
                    buzzer    = ~buzzer;
                    lamp      = ~lamp;
                end
                else
                    blink_cnt = nxt[3:0];
            end
            else
            begin
                buzzer = 1'b0;
                lamp   = 1'b0;
            end
        endfunction

        // returns 0 when the edge is dropped
        function bit take_edge(int s, logic [CAP_W-1:0] cap);
            logic [CAP_W-1:0] width;
            int cm;
            if (armed != sensor_t'(s + 1))
                return 1'b0;
            if (!edge_pending[s])
            begin
                edge_base[s]    = cap;
                edge_pending[s] = 1'b1;
            end
            else
            begin
                width = cap - edge_base[s];
                cm    = width / COUNTS_PER_CM;
                if (cm <= range_lim)
                begin
                    dist_cm[s] = cm[DIST_W-1:0];
                    stored_reads++;
                end
                edge_pending[s] = 1'b0;
                armed           = SENSOR_NONE;
            end
            return 1'b1;
        endfunction

        // predicts the result of one accepted event; 0 if the event had no effect
        function bit note_event(func_t f, logic [CAP_W-1:0] cap);
            ranger_report_t r;
            sensor_t trig;
            bit took;
            int nxt;
            took = 1'b1;
            trig = SENSOR_NONE;
            case (f)
                FUNC_TICK:
                begin
                    nxt = tick_cnt + 1;
                    if (nxt >= slot_len)
                    begin
                        tick_cnt = '0;
                        end_slot();
                        trig = cur_slot;
                        triggers++;
                    end
                    else
                        tick_cnt = nxt[3:0];
                end
                FUNC_ECHO_ONE: took = take_edge(0, cap);
                FUNC_ECHO_TWO: took = take_edge(1, cap);
                default:       took = 1'b0;
            endcase
            if (warn)
                warned++;
            r.trig     = trig;
            r.dist_one = dist_cm[0];
            r.dist_two = dist_cm[1];
            r.buzzer   = buzzer;
            r.lamp     = lamp;
            r.warn     = warn;
            expected_reports.push_back(r);
            return took;
        endfunction

        function void check_result(ranger_report_t got);
            ranger_report_t want;
            checked++;
            if (expected_reports.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: trig %0d d1 %0d d2 %0d buz %0b lamp %0b warn %0b",
                             got.trig, got.dist_one, got.dist_two, got.buzzer, got.lamp,
                             got.warn);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.trig !== want.trig || got.dist_one !== want.dist_one ||
                got.dist_two !== want.dist_two || got.buzzer !== want.buzzer ||
                got.lamp !== want.lamp || got.warn !== want.warn)
            begin
                if (mismatches < 10)
                begin
                    $display("mismatch at result %0d", checked);
                    $display("  exp: trig %0d d1 %0d d2 %0d buz %0b lamp %0b warn %0b",
                             want.trig, want.dist_one, want.dist_two, want.buzzer, want.lamp,
                             want.warn);
                    $display("  got: trig %0d d1 %0d d2 %0d buz %0b lamp %0b warn %0b",
                             got.trig, got.dist_one, got.dist_two, got.buzzer, got.lamp,
                             got.warn);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

endpackage

>>> tb/dual_ultrasonic_ranger_warning_tb.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger_warning_tb
// Drives ticks and echo edges into the ranger, a short directed sequence at
// the reset settings followed by random well-formed echo pulses mixed with
// stray edges, under six register settings and three idle/stall patterns.
// Every result is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module dual_ultrasonic_ranger_warning_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import durw_pkg::*;
    import ranger_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASES       = 6;
    localparam int PHASE_EVENTS = 280;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    func_t                func         = FUNC_TICK;
    logic [CAP_W-1:0]     capture_time = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    sensor_t              trigger_sensor;
    dist_t                distance_one;
    dist_t                distance_two;
    logic                 buzzer_on;
    logic                 lamp_on;
    logic                 warning_active;

    ranger_scoreboard     ranging;
    int                   send_idle_pct    = 0;
    int                   recv_stall_pct   = 0;
    int                   events_sent      = 0;
    int                   effective_events = 0;
    int                   cycle_count      = 0;

    dual_ultrasonic_ranger_warning u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .capture_time   (capture_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .trigger_sensor (trigger_sensor),
        .distance_one   (distance_one),
        .distance_two   (distance_two),
        .buzzer_on      (buzzer_on),
        .lamp_on        (lamp_on),
        .warning_active (warning_active)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_event(func_t f, logic [CAP_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        capture_time <= c;
        do
            @(posedge clk);
        while (in_stall);
        if (ranging.note_event(f, c))
            effective_events++;
        events_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge clk);
        ranging.write_reg(idx, val[CFG_W-1:0]);
    endtask

    task automatic configure(int slots, int warn_at, int max_range, int blink_max);
        write_reg(CFG_SLOT_TICKS, slots);
        write_reg(CFG_WARN_CM, warn_at);
        write_reg(CFG_MAX_CM, max_range);
        write_reg(CFG_MAX_BLINK_SLOTS, blink_max);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ranging.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly complete pulses on the armed sensor, some stray edges and unused codes
    task automatic random_event();
        int r;
        int s;
        int top;
        logic [16:0] span;
        func_t f;
        logic [CAP_W-1:0] c;
        r = $urandom_range(0, 99);
        c = CAP_W'($urandom);
        if (r < 40)
            f = FUNC_TICK;
        else if (r < 80)
        begin
            if (ranging.armed == SENSOR_ONE)
                s = 0;
            else if (ranging.armed == SENSOR_TWO)
                s = 1;
            else
                s = $urandom_range(0, 1);
            f = (s == 1) ? FUNC_ECHO_TWO : FUNC_ECHO_ONE;
            if (ranging.edge_pending[s])
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    top = ranging.warn_lim + 30;
                    if (top > 564)
                        top = 564;
                    span = 17'($urandom_range(0, top) * COUNTS_PER_CM
                               + $urandom_range(0, 115));
                end
                else if (r < 85)
                    span = 17'($urandom);
                else
                    case ($urandom_range(0, 3))
                        0:       span = '0;
                        1:       span = 17'h0FFFF;
                        2:       span = 17'(ranging.range_lim * COUNTS_PER_CM + 115);
                        default: span = 17'((ranging.range_lim + 1) * COUNTS_PER_CM);
                    endcase
                c = ranging.edge_base[s] + span[CAP_W-1:0];
            end
        end
        else if (r < 93)
            f = ($urandom_range(0, 1) == 1) ? FUNC_ECHO_TWO : FUNC_ECHO_ONE;
        else
            f = FUNC_UNUSED;
        send_event(f, c);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                ranging.check_result('{trigger_sensor, distance_one, distance_two,
                                       buzzer_on, lamp_on, warning_active});
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 ranging.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int start;
        ranging = new();
        repeat (10) @(posedge clk);
        rst_n          <= 1'b1;
        send_idle_pct  = 15;
        recv_stall_pct = 64;
        @(posedge clk);

        // reset settings: unused code, stray edge, wrapped pulse, slot changes
        send_event(FUNC_UNUSED, 16'hFFFF);
        send_event(FUNC_ECHO_ONE, 16'hFF00);
        send_event(FUNC_ECHO_ONE, 16'h0D98);
        send_event(FUNC_ECHO_ONE, 16'h0000);
        repeat (5) send_event(FUNC_TICK, 16'h0000);
        send_event(FUNC_ECHO_TWO, 16'h0000);
        send_event(FUNC_ECHO_TWO, 16'hFFFF);
        repeat (5) send_event(FUNC_TICK, 16'hFFFF);
        send_event(FUNC_ECHO_ONE, 16'hAAAA);
        send_event(FUNC_ECHO_TWO, 16'h5555);
        send_event(FUNC_ECHO_ONE, 16'h2A3A);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:       configure(1, 511, 565, 15);
                1:       configure(0, 0, 0, 0);
                2:       configure(15, 200, 300, 1);
                3:       configure($urandom_range(1, 6), $urandom_range(0, 511),
                                   $urandom_range(0, 565), $urandom_range(1, 15));
                4:       configure(2, 60, 380, 4);
                default: configure($urandom_range(0, 15), $urandom_range(20, 120),
                                   $urandom_range(100, 565), $urandom_range(0, 15));
            endcase
            if (p < 2)
            begin
                send_idle_pct  = 15;
                recv_stall_pct = 64;
            end
            else if (p < 4)
            begin
                send_idle_pct  = 64;
                recv_stall_pct = 15;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            start = events_sent;
            while (events_sent - start < PHASE_EVENTS)
                random_event();
        end
        drain();

        $display("%0d events (%0d with effect) over %0d register settings, %0d results checked",
                 events_sent, effective_events, PHASES + 1, ranging.checked);
        $display("%0d slot triggers, %0d distances stored, %0d results with warning",
                 ranging.triggers, ranging.stored_reads, ranging.warned);
        if (ranging.mismatches == 0 && ranging.pending() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d results missing", ranging.mismatches,
                     ranging.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
